FILE: sv/hftd_pkg.sv
package hftd_pkg;

   localparam int KIND_W      = 2;
   localparam int NODE_IDX_W  = 9;
   localparam int SYMBOL_W    = 8;
   localparam int SYM_COUNT_W = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int BYTE_BITS   = 8;
   localparam int BIT_CNT_W   = 4;

   localparam logic [KIND_W-1:0] KIND_NODE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LEAF = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DATA = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_BITS   = 2'd1;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [NODE_IDX_W-1:0] node_index;
      logic [NODE_IDX_W-1:0] left_child;
      logic [NODE_IDX_W-1:0] right_child;
      logic [SYMBOL_W-1:0]   data_byte;
   } req_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last_of_run;
      logic                finished;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } bit_ctrl_type;

   typedef struct packed {
      logic msb;
      logic empty;
   } bit_stat_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } walk_state_type;

endpackage

FILE: sv/hftd_mod.sv
module hftd_mod #(
   parameter int IN_W = 9,
   parameter int DIV  = 512
) (
   input  logic [IN_W-1:0]          value,
   output logic [$clog2(DIV)-1:0]   remainder
);

   localparam int OUT_W = $clog2(DIV);

   generate
      if (DIV >= (1 << IN_W)) begin : g_pass
         assign remainder = OUT_W'(value);
      end else begin : g_div
         // reciprocal estimate is at most one low; one subtract corrects it
         localparam int RECIP = (1 << IN_W) / DIV;
         localparam int RW    = $clog2(RECIP + 1);
         localparam int PW    = IN_W + RW;

         logic [PW-1:0]   prod;
         logic [RW-1:0]   quot;
         logic [IN_W-1:0] rem;

         assign prod      = PW'(value) * PW'(RECIP);
         assign quot      = prod[PW-1:IN_W];
         assign rem       = value - IN_W'(PW'(quot) * PW'(DIV));
         assign remainder = (rem >= IN_W'(DIV)) ? OUT_W'(rem - IN_W'(DIV)) : OUT_W'(rem);
      end
   endgenerate

endmodule

FILE: sv/hftd_bits.sv
module hftd_bits (
   input  logic                               clock,
   input  logic                               reset,
   input  hftd_pkg::bit_ctrl_type             ctrl,
   input  logic [hftd_pkg::BYTE_BITS-1:0]     data_byte,
   output hftd_pkg::bit_stat_type             stat
);

   import hftd_pkg::*;

   logic [BYTE_BITS-1:0] data_ff, data_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      data_in = data_ff;
      cnt_in  = cnt_ff;
      if (ctrl.load) begin
         data_in = data_byte;
         cnt_in  = BIT_CNT_W'(BYTE_BITS);
      end else if (ctrl.shift) begin
         data_in = {data_ff[BYTE_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - BIT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign stat.msb   = data_ff[BYTE_BITS-1];
   assign stat.empty = (cnt_ff == '0);

   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift |-> cnt_ff != '0)
      else $error("bit shifter advanced past the end of the byte");

endmodule

FILE: sv/hftd_walk.sv
module hftd_walk #(
   parameter int NODE_SLOTS   = 512,
   parameter int SYMBOL_SLOTS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hftd_pkg::req_type                   req,
   input  logic                                req_accept,
   input  logic [$clog2(NODE_SLOTS)-1:0]       root,
   input  logic [hftd_pkg::CSR_DATA_W-1:0]     total_bits,
   output logic                                busy,
   output hftd_pkg::bit_ctrl_type              bit_ctrl,
   input  hftd_pkg::bit_stat_type              bit_stat,
   output logic                                push,
   output hftd_pkg::rsp_type                   push_data,
   input  logic                                push_ok
);

   import hftd_pkg::*;

   localparam int NODE_AW = $clog2(NODE_SLOTS);
   localparam int SYM_AW  = $clog2(SYMBOL_SLOTS);
   localparam int ENTRY_W = 2 * NODE_AW;

   // node table holds {left, right}, both already reduced to a slot index
   logic [ENTRY_W-1:0]  child_mem [NODE_SLOTS];
   logic [SYMBOL_W-1:0] leaf_mem  [SYMBOL_SLOTS];
   logic [ENTRY_W-1:0]  entry_ff;
   logic [SYMBOL_W-1:0] leaf_ff;

   walk_state_type       state_ff, state_in;
   logic                 check_ff, check_in;
   logic [NODE_AW-1:0]   cur_ff, cur_in;
   logic [NODE_AW-1:0]   node_ff, node_in;
   logic [CSR_DATA_W-1:0] bits_ff, bits_in;
   logic                 done_ff, done_in;
   logic                 pend_v_ff, pend_v_in;
   logic [SYMBOL_W-1:0]  pend_sym_ff, pend_sym_in;
   logic                 pend_fin_ff, pend_fin_in;

   logic                 rd_en;
   logic [NODE_AW-1:0]   rd_addr;
   logic [SYM_AW-1:0]    leaf_addr;
   logic [NODE_AW-1:0]   wr_node;
   logic [SYM_AW-1:0]    wr_leaf;
   logic [NODE_AW-1:0]   left_n;
   logic [NODE_AW-1:0]   right_n;
   logic [NODE_AW-1:0]   start_node;
   logic [NODE_AW-1:0]   child;
   logic [CSR_DATA_W-1:0] bits_inc;
   logic                 is_leaf;
   logic                 at_end;
   logic                 go_data;

   hftd_mod #(.IN_W(NODE_IDX_W), .DIV(NODE_SLOTS)) u_mod_node (
      .value(req.node_index), .remainder(wr_node));
   hftd_mod #(.IN_W(NODE_IDX_W), .DIV(SYMBOL_SLOTS)) u_mod_leaf (
      .value(req.node_index), .remainder(wr_leaf));
   hftd_mod #(.IN_W(NODE_IDX_W), .DIV(NODE_SLOTS)) u_mod_left (
      .value(req.left_child), .remainder(left_n));
   hftd_mod #(.IN_W(NODE_IDX_W), .DIV(NODE_SLOTS)) u_mod_right (
      .value(req.right_child), .remainder(right_n));
   hftd_mod #(.IN_W(NODE_AW), .DIV(SYMBOL_SLOTS)) u_mod_rd (
      .value(rd_addr - NODE_AW'(1)), .remainder(leaf_addr));

   always_ff @(posedge clock) begin
      if (req_accept && req.kind == KIND_NODE) begin
         child_mem[wr_node] <= {left_n, right_n};
      end
      if (rd_en) begin
         entry_ff <= child_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req.kind == KIND_LEAF) begin
         leaf_mem[wr_leaf] <= req.data_byte;
      end
      if (rd_en) begin
         leaf_ff <= leaf_mem[leaf_addr];
      end
   end

   assign start_node = (cur_ff == '0) ? root : cur_ff;
   assign is_leaf    = check_ff && (entry_ff == '0);
   assign at_end     = bit_stat.empty || done_ff;
   assign child      = bit_stat.msb ? entry_ff[NODE_AW-1:0] : entry_ff[ENTRY_W-1:NODE_AW];
   assign bits_inc   = bits_ff + CSR_DATA_W'(1);
   assign go_data    = req_accept && (req.kind == KIND_DATA) && !done_ff
                       && (bits_ff < total_bits);
   assign busy       = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go_data) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (!is_leaf && at_end && (!pend_v_ff || push_ok)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rd_en       = 1'b0;
      rd_addr     = start_node;
      bit_ctrl    = '0;
      push        = 1'b0;
      push_data   = '{symbol: pend_sym_ff, last_of_run: 1'b0, finished: pend_fin_ff};
      cur_in      = cur_ff;
      node_in     = node_ff;
      check_in    = check_ff;
      bits_in     = bits_ff;
      done_in     = done_ff;
      pend_v_in   = pend_v_ff;
      pend_sym_in = pend_sym_ff;
      pend_fin_in = pend_fin_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_en         = 1'b1;
            check_in      = 1'b0;
            bit_ctrl.load = go_data;
         end
         ST_WALK: begin
            if (is_leaf) begin
               // hold the new symbol back until the byte shows whether it is the last
               if (!pend_v_ff || push_ok) begin
                  push        = pend_v_ff;
                  pend_v_in   = 1'b1;
                  pend_sym_in = leaf_ff;
                  pend_fin_in = done_ff;
                  cur_in      = '0;
                  check_in    = 1'b0;
                  rd_en       = 1'b1;
                  rd_addr     = root;
               end
            end else begin
               check_in = 1'b0;
               if (check_ff) cur_in = node_ff;
               if (!at_end) begin
                  bit_ctrl.shift = 1'b1;
                  bits_in        = bits_inc;
                  done_in        = (bits_inc == total_bits);
                  rd_en          = 1'b1;
                  if (child == '0) begin
                     cur_in  = '0;
                     rd_addr = root;
                  end else begin
                     node_in  = child;
                     check_in = 1'b1;
                     rd_addr  = child;
                  end
               end else if (!pend_v_ff || push_ok) begin
                  push                  = pend_v_ff;
                  push_data.last_of_run = 1'b1;
                  pend_v_in             = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         check_ff  <= 1'b0;
         cur_ff    <= '0;
         bits_ff   <= '0;
         done_ff   <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         check_ff  <= check_in;
         cur_ff    <= cur_in;
         bits_ff   <= bits_in;
         done_ff   <= done_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      pend_sym_ff <= pend_sym_in;
      pend_fin_ff <= pend_fin_in;
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ok)
      else $error("symbol pushed while the output register is blocked");

   a_check_walk: assert property (@(posedge clock) disable iff (reset)
      check_ff |-> state_ff == ST_WALK)
      else $error("leaf check pending outside a walk");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      ($past(done_ff) && !$past(reset)) |-> done_ff)
      else $error("finished flag dropped without reset");

endmodule

FILE: sv/huffman_tree_bit_decoder.sv
// channel   direction  handshake               payload
// req_      in         req_valid / req_stall   hftd_pkg::req_type
// rsp_      out        rsp_valid / rsp_stall   hftd_pkg::rsp_type
// csr_      in         csr_valid / csr_ready   csr_index, csr_data
//
// Loads and skipped data bytes are taken without a walk. A decoded data byte holds the
// request channel in a walk: a dependent node-table read for each coded bit (eight unless
// the bit budget ends inside the byte), a refetch of the root entry for each symbol,
// plus accept and close.
// Reset is synchronous; it clears the walk, the bit count and the CSRs, not the tables.
// rsp_stall holds the walk while a decoded symbol waits on a full output register.
module huffman_tree_bit_decoder #(
   parameter int NODE_SLOTS   = 512,
   parameter int SYMBOL_SLOTS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  hftd_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output hftd_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hftd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hftd_pkg::CSR_DATA_W-1:0]     csr_data
);

   import hftd_pkg::*;

   localparam int NODE_AW = $clog2(NODE_SLOTS);
   // root for a symbol count of zero: 2*0-1 wraps to all ones in 32 bits
   localparam logic [NODE_AW-1:0] ROOT_WRAP = NODE_AW'(64'd4294967295 % NODE_SLOTS);

   logic [NODE_AW-1:0]      root_ff, root_in;
   logic [NODE_AW-1:0]      root_calc;
   logic [CSR_DATA_W-1:0]   total_bits_ff, total_bits_in;
   logic [SYM_COUNT_W:0]    root_raw;
   logic                    csr_wr;

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_payload_ff, rsp_payload_in;

   logic                    req_accept;
   logic                    walk_busy;
   logic                    push;
   logic                    push_ok;
   rsp_type                 push_data;
   bit_ctrl_type            bit_ctrl;
   bit_stat_type            bit_stat;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign root_raw  = {csr_data[SYM_COUNT_W-1:0], 1'b0} - (SYM_COUNT_W + 1)'(1);

   hftd_mod #(.IN_W(SYM_COUNT_W + 1), .DIV(NODE_SLOTS)) u_mod_root (
      .value(root_raw), .remainder(root_calc));

   always_comb begin
      root_in       = root_ff;
      total_bits_in = total_bits_ff;
      if (csr_wr && csr_index == CSR_SYMBOL_COUNT) begin
         root_in = (csr_data[SYM_COUNT_W-1:0] == '0) ? ROOT_WRAP : root_calc;
      end
      if (csr_wr && csr_index == CSR_TOTAL_BITS) begin
         total_bits_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff       <= NODE_AW'(1);
         total_bits_ff <= '0;
      end else begin
         root_ff       <= root_in;
         total_bits_ff <= total_bits_in;
      end
   end

   assign req_stall  = walk_busy;
   assign req_accept = req_valid && !req_stall;

   hftd_bits u_bits (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (bit_ctrl),
      .data_byte (req_payload.data_byte),
      .stat      (bit_stat)
   );

   hftd_walk #(
      .NODE_SLOTS   (NODE_SLOTS),
      .SYMBOL_SLOTS (SYMBOL_SLOTS)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .req        (req_payload),
      .req_accept (req_accept),
      .root       (root_ff),
      .total_bits (total_bits_ff),
      .busy       (walk_busy),
      .bit_ctrl   (bit_ctrl),
      .bit_stat   (bit_stat),
      .push       (push),
      .push_data  (push_data),
      .push_ok    (push_ok)
   );

   // output register: refill in the same cycle the held symbol drains
   assign push_ok = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (push) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = push_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import hftd_pkg::*;

   localparam logic [KIND_W-1:0]    KIND_SPARE    = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI  = 2'd3;
   localparam logic [31:0]          ALL_BITS      = 32'hFFFF_FFFF;
   localparam int                   SETTLE_CYCLES = 24;
   localparam int                   LIMIT_CYCLES  = 400000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_payload;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // decoder state as the testbench sees it
   logic [17:0]          node_table [0:511];
   logic [SYMBOL_W-1:0]  leaf_table [0:255];
   logic [8:0]           walk_node;
   logic [31:0]          bits_seen;
   logic                 decode_done;
   logic [8:0]           symbol_count_reg;
   logic [31:0]          bit_budget;
   rsp_type              expected_symbols[$];

   bit          tree_member [0:511];
   int          tree_nodes[$];
   int          sender_idle_pct;
   int          receiver_idle_pct;
   int          hold_cycles;
   int          sent_items;
   int          error_count;
   int unsigned cycle_count;

   huffman_tree_bit_decoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: long hold-off first, then random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   task automatic check_symbol(input rsp_type got);
      rsp_type want;
      if (expected_symbols.size() == 0) begin
         if (error_count < 10)
            $display("%0t: symbol %h with nothing expected", $time, got.symbol);
         error_count++;
      end else begin
         want = expected_symbols.pop_front();
         if (got.symbol !== want.symbol || got.last_of_run !== want.last_of_run ||
             got.finished !== want.finished) begin
            if (error_count < 10)
               $display("%0t: expected symbol %h last %b finished %b, got %h %b %b",
                        $time, want.symbol, want.last_of_run, want.finished,
                        got.symbol, got.last_of_run, got.finished);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_symbol(rsp_payload);
   end

   function automatic logic [8:0] root_index();
      return {symbol_count_reg[7:0], 1'b0} - 9'd1;
   endfunction

   task automatic decode_request(input req_type r);
      logic [8:0]  node, next_node, slot;
      logic [17:0] entry;
      rsp_type     held;
      bit          have_held, at_end;
      int          b;
      case (r.kind)
         KIND_NODE: node_table[r.node_index] = {r.left_child, r.right_child};
         KIND_LEAF: leaf_table[r.node_index[7:0]] = r.data_byte;
         KIND_DATA: begin
            if (!decode_done && bits_seen < bit_budget) begin
               node = (walk_node == '0) ? root_index() : walk_node;
               have_held = 1'b0;
               at_end = 1'b0;
               b = 7;
               while (b >= 0 && !at_end) begin
                  entry = node_table[node];
                  next_node = r.data_byte[b] ? entry[8:0] : entry[17:9];
                  bits_seen = bits_seen + 1;
                  at_end = (bits_seen == bit_budget);
                  if (next_node == '0) begin
                     // absent child: back to the root, nothing decoded
                     walk_node = '0;
                     node = root_index();
                  end else if (node_table[next_node] == '0) begin
                     if (have_held)
                        expected_symbols.push_back(held);
                     slot = next_node - 9'd1;
                     held.symbol = leaf_table[slot[7:0]];
                     held.last_of_run = 1'b0;
                     held.finished = at_end;
                     have_held = 1'b1;
                     walk_node = '0;
                     node = root_index();
                  end else begin
                     walk_node = next_node;
                     node = next_node;
                  end
                  b--;
               end
               if (at_end)
                  decode_done = 1'b1;
               if (have_held) begin
                  held.last_of_run = 1'b1;
                  expected_symbols.push_back(held);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_request(input req_type r);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      decode_request(r);
      if (r.kind != KIND_SPARE)
         sent_items++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_SYMBOL_COUNT: symbol_count_reg = value[8:0];
         CSR_TOTAL_BITS:   bit_budget = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // drop the request, wait for every symbol, then let a silent walk finish
   task automatic drain_symbols();
      req_valid = 1'b0;
      while (expected_symbols.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic req_type random_request();
      req_type r;
      r.kind = KIND_DATA;
      r.node_index = 9'($urandom_range(0, 511));
      r.left_child = 9'($urandom_range(0, 511));
      r.right_child = 9'($urandom_range(0, 511));
      r.data_byte = 8'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic load_node(input logic [8:0] idx, input logic [8:0] lc,
                            input logic [8:0] rc);
      req_type r;
      r = random_request();
      r.kind = KIND_NODE;
      r.node_index = idx;
      r.left_child = lc;
      r.right_child = rc;
      send_request(r);
   endtask

   task automatic load_leaf(input logic [8:0] idx, input logic [7:0] sym);
      req_type r;
      r = random_request();
      r.kind = KIND_LEAF;
      r.node_index = idx;
      r.data_byte = sym;
      send_request(r);
   endtask

   task automatic send_data(input logic [7:0] coded);
      req_type r;
      r = random_request();
      r.data_byte = coded;
      send_request(r);
   endtask

   task automatic set_symbol_count(input logic [8:0] count);
      // upper data bits carry junk, only the low nine count
      write_csr(CSR_SYMBOL_COUNT, ($urandom() & ~32'h1FF) | count);
   endtask

   // root 511 with two leaves: every coded bit decodes a symbol
   task automatic load_shallow_tree();
      drain_symbols();
      set_symbol_count(9'd256);
      load_node(9'd511, 9'd256, 9'd257);
      load_node(9'd256, '0, '0);
      load_node(9'd257, '0, '0);
      load_leaf(9'd255, 8'hFF);
      load_leaf(9'd256, 8'h00);
   endtask

   function automatic int take_free_node();
      int n;
      n = $urandom_range(1, 511);
      while (tree_member[n])
         n = $urandom_range(1, 511);
      tree_member[n] = 1'b1;
      tree_nodes.push_back(n);
      return n;
   endfunction

   task automatic build_tree(input int leaf_target);
      int         frontier[$];
      int         pick, n, lc, rc, absent;
      logic [8:0] slot;
      for (int i = 0; i < 512; i++)
         tree_member[i] = 1'b0;
      tree_nodes.delete();
      tree_member[0] = 1'b1;
      n = int'(root_index());
      tree_member[n] = 1'b1;
      tree_nodes.push_back(n);
      frontier.push_back(n);
      while (frontier.size() < leaf_target) begin
         pick = $urandom_range(0, frontier.size() - 1);
         n = frontier[pick];
         frontier.delete(pick);
         absent = $urandom_range(0, 11);
         lc = (absent == 0) ? 0 : take_free_node();
         rc = (absent == 1) ? 0 : take_free_node();
         if (lc != 0)
            frontier.push_back(lc);
         if (rc != 0)
            frontier.push_back(rc);
         load_node(9'(n), 9'(lc), 9'(rc));
      end
      foreach (frontier[i]) begin
         load_node(9'(frontier[i]), '0, '0);
         slot = 9'(frontier[i] - 1);
         load_leaf({1'($urandom_range(0, 1)), slot[7:0]}, 8'($urandom_range(0, 255)));
      end
   endtask

   // off-tree traffic; node writes only point back into the live tree
   task automatic send_noise();
      req_type r;
      int      n;
      r = random_request();
      case ($urandom_range(0, 2))
         0: r.kind = KIND_SPARE;
         1: r.kind = KIND_LEAF;
         default: begin
            n = $urandom_range(1, 511);
            while (tree_member[n])
               n = $urandom_range(1, 511);
            r.kind = KIND_NODE;
            r.node_index = 9'(n);
            r.left_child = 9'(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]);
            r.right_child = $urandom_range(0, 1) ?
                            9'(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]) : 9'd0;
         end
      endcase
      send_request(r);
   endtask

   task automatic test_zero_budget();
      req_type r;
      send_data(8'h00);
      send_data(8'hFF);
      r = random_request();
      r.kind = KIND_SPARE;
      send_request(r);
      drain_symbols();
   endtask

   task automatic test_full_byte_decode();
      load_shallow_tree();
      write_csr(CSR_TOTAL_BITS, ALL_BITS);
      send_data(8'hFF);
      send_data(8'h00);
      send_data(8'h5A);
      drain_symbols();
   endtask

   task automatic test_absent_child();
      drain_symbols();
      set_symbol_count(9'd1);
      load_node(9'd0, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
      load_node(9'd1, '0, 9'd2);
      load_node(9'd2, '0, '0);
      load_leaf(9'd1, 8'hC3);
      send_data(8'h55);
      send_data(8'h80);
      drain_symbols();
   endtask

   task automatic test_exhausted_budget();
      write_csr(CSR_TOTAL_BITS, bits_seen);
      send_data(8'($urandom_range(0, 255)));
      drain_symbols();
      write_csr(CSR_TOTAL_BITS, bits_seen - 1);
      send_data(8'($urandom_range(0, 255)));
      drain_symbols();
      write_csr(CSR_SPARE_LO, $urandom());
      write_csr(CSR_SPARE_HI, $urandom());
      write_csr(CSR_TOTAL_BITS, ALL_BITS);
   endtask

   task automatic test_receiver_backpressure();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      load_shallow_tree();
      fork
         begin
            @(posedge clock);
            hold_cycles = 300;
         end
      join_none
      repeat (12) send_data(8'($urandom_range(0, 255)));
      drain_symbols();
   endtask

   task automatic test_random_trees(input int sender_pct, input int receiver_pct,
                                    input int item_goal);
      int         stop_at;
      logic [8:0] count;
      sender_idle_pct = sender_pct;
      receiver_idle_pct = receiver_pct;
      stop_at = sent_items + item_goal;
      while (sent_items < stop_at) begin
         drain_symbols();
         case ($urandom_range(0, 9))
            0:       count = 9'd1;
            1:       count = 9'd256;
            default: count = 9'($urandom_range(2, 255));
         endcase
         set_symbol_count(count);
         build_tree(($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8));
         repeat ($urandom_range(4, 16)) begin
            if ($urandom_range(0, 9) == 0)
               send_noise();
            else
               send_data(8'($urandom_range(0, 255)));
         end
      end
      drain_symbols();
   endtask

   // stop on the third bit of a byte; everything after that is dropped
   task automatic test_bit_budget_end();
      sender_idle_pct = 0;
      receiver_idle_pct = 30;
      load_shallow_tree();
      write_csr(CSR_TOTAL_BITS, bits_seen + 32'd11);
      send_data(8'($urandom_range(0, 255)));
      send_data(8'($urandom_range(0, 255)));
      send_data(8'($urandom_range(0, 255)));
      load_leaf(9'd255, 8'($urandom_range(0, 255)));
      drain_symbols();
      write_csr(CSR_TOTAL_BITS, ALL_BITS);
      send_data(8'($urandom_range(0, 255)));
      drain_symbols();
   endtask

   initial begin
      for (int i = 0; i < 512; i++)
         node_table[i] = '0;
      for (int i = 0; i < 256; i++)
         leaf_table[i] = '0;
      walk_node = '0;
      bits_seen = '0;
      decode_done = 1'b0;
      symbol_count_reg = 9'd1;
      bit_budget = '0;
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      hold_cycles = 0;
      sent_items = 0;
      error_count = 0;
      cycle_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_zero_budget();
      test_full_byte_decode();
      test_absent_child();
      test_exhausted_budget();
      test_receiver_backpressure();
      test_random_trees(12, 68, 45);
      test_random_trees(68, 12, 45);
      test_random_trees(0, 0, 45);
      test_bit_budget_end();

      drain_symbols();
      if (error_count == 0 && expected_symbols.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: sim.f
sv/hftd_pkg.sv
sv/hftd_mod.sv
sv/hftd_bits.sv
sv/hftd_walk.sv
sv/huffman_tree_bit_decoder.sv
dv/testbench.sv
